>>> design/crosspoint_status_parser_unit_macros.svh
// Assertion macros for the crosspoint status parser unit.
// Included by the top level; no other dependencies.
`ifndef CROSSPOINT_STATUS_PARSER_UNIT_MACROS_SVH
`define CROSSPOINT_STATUS_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSPU_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSPU_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> design/cspu_pkg.sv
// Shared types and constants for the crosspoint status parser unit.
// No dependencies.
package cspu_pkg;

   localparam int BYTE_W  = 8;
   localparam int ID_W    = 7;
   localparam int PREV_W  = 8;
   localparam int COUNT_W = 8;
   localparam int LEVEL_W = 4;

   // command byte: flag in bit 7, kind in upper nibble, level in lower nibble
   localparam int CMD_BIT = 7;
   localparam logic [3:0] CMD_AUDIO_SET = 4'h9;
   localparam logic [3:0] CMD_VIDEO_SET = 4'hA;

   localparam logic signed [PREV_W-1:0] PREV_UNKNOWN = -8'sd1;

   // per-transaction control from the parser to the route map stage
   typedef struct packed {
      logic            load_dest;  // data byte is a destination
      logic            emit;       // data byte completes an in-range report
      logic [ID_W-1:0] dest;       // pending destination
      logic [ID_W-1:0] data;       // low 7 bits of the data byte
   } cspu_ctrl_type;

endpackage

>>> design/cspu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cspu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cspu_parser.sv
// Command/data byte parser: phase state machine and pending destination.
// Depends on cspu_pkg.
module cspu_parser #(
   parameter int NUM_DESTINATIONS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          advance,
   input  logic [cspu_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          idle_expired,
   input  logic [cspu_pkg::LEVEL_W-1:0]  router_level,
   output cspu_pkg::cspu_ctrl_type       ctrl
);
   import cspu_pkg::*;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_DEST = 3'b010,
      PHASE_SRC  = 3'b100
   } phase_type;

   phase_type       phase_ff, phase_in, phase_eff;
   logic [ID_W-1:0] pending_ff, pending_in;
   logic            is_cmd, set_match, dest_in_range;

   assign is_cmd        = rx_byte[CMD_BIT];
   assign set_match     = (rx_byte[7:4] inside {CMD_AUDIO_SET, CMD_VIDEO_SET}) &&
                          (rx_byte[3:0] == router_level);
   assign dest_in_range = {1'b0, pending_ff} < COUNT_W'(NUM_DESTINATIONS);
   // idle gap drops the parser to idle before the byte is looked at
   assign phase_eff     = idle_expired ? PHASE_IDLE : phase_ff;

   always_comb begin
      phase_in       = PHASE_IDLE;
      pending_in     = pending_ff;
      ctrl.load_dest = 1'b0;
      ctrl.emit      = 1'b0;
      ctrl.dest      = pending_ff;
      ctrl.data      = rx_byte[ID_W-1:0];
      if (is_cmd) begin
         phase_in = set_match ? PHASE_DEST : PHASE_IDLE;
      end else begin
         case (phase_eff)
            PHASE_DEST: begin
               phase_in       = PHASE_SRC;
               pending_in     = rx_byte[ID_W-1:0];
               ctrl.load_dest = in_valid;
            end
            PHASE_SRC: begin
               phase_in  = PHASE_IDLE;
               ctrl.emit = in_valid && dest_in_range;
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         pending_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

>>> design/crosspoint_status_parser_unit.sv
// Crosspoint status parser unit: parses routing-switcher link bytes and
// reports each completed crosspoint set with the source it replaced.
// Channels: req_ (one received byte plus idle-gap flag per transaction) and
// rsp_ (one crosspoint report), both valid/ready. csr_ writes router_level.
// Only a source byte that completes an in-range set command yields a report;
// every other byte is consumed silently.
// A byte is held in the input register; when it leaves, its report is
// loaded into the output register that drives rsp_.
// Throughput: one byte per cycle unless a held report stalls. The route map
// RAM read for a destination is issued when the destination byte leaves
// the input register, so the source byte can follow on the very next cycle.
// Stall: a held report blocks only a new report; other bytes keep flowing,
// and the input register absorbs one byte while the output is full.
// Reset: parser idle, router_level 0, count 0, and all map entries unknown
// at once through per-entry known bits (no clearing pass).
`include "crosspoint_status_parser_unit_macros.svh"

module crosspoint_status_parser_unit #(
   parameter int NUM_DESTINATIONS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cspu_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                               req_idle_expired,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cspu_pkg::ID_W-1:0]          rsp_destination,
   output logic [cspu_pkg::ID_W-1:0]          rsp_source,
   output logic signed [cspu_pkg::PREV_W-1:0] rsp_previous_source,
   output logic                               rsp_route_changed,
   output logic [cspu_pkg::COUNT_W-1:0]       rsp_destinations_seen,
   input  logic                               csr_wr_en,
   input  logic [cspu_pkg::LEVEL_W-1:0]       csr_wr_data
);
   import cspu_pkg::*;

   localparam int AW = $clog2(NUM_DESTINATIONS);

   // configuration
   logic [LEVEL_W-1:0] level_ff;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_idle_ff;

   cspu_ctrl_type ctrl;
   logic          advance;

   // route map
   logic [NUM_DESTINATIONS-1:0] known_ff;
   logic [ID_W-1:0]             map_rd_data;
   logic                        map_rd_en, map_wr_en;
   logic [AW-1:0]               wr_addr;

   // report assembly
   logic [COUNT_W-1:0]        count_ff, count_in, dest_plus;
   logic signed [PREV_W-1:0]  prev_src;
   logic                      changed;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]           rsp_dest_ff, rsp_src_ff;
   logic signed [PREV_W-1:0]  rsp_prev_ff;
   logic                      rsp_changed_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (csr_wr_en) begin
         level_ff <= csr_wr_data;
      end
   end

   // a report can leave only if the output register is free or draining
   assign advance   = in_valid_ff && (!ctrl.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
         in_idle_ff <= req_idle_expired;
      end
   end

   cspu_parser #(
      .NUM_DESTINATIONS(NUM_DESTINATIONS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .idle_expired(in_idle_ff),
      .router_level(level_ff),
      .ctrl        (ctrl)
   );

   // read at the destination byte; data is held until the source byte uses it
   assign map_rd_en = advance && ctrl.load_dest;
   assign map_wr_en = advance && ctrl.emit;
   assign wr_addr   = ctrl.dest[AW-1:0];

   cspu_ram #(
      .WIDTH(ID_W),
      .DEPTH(NUM_DESTINATIONS)
   ) u_route_map (
      .clock  (clock),
      .wr_en  (map_wr_en),
      .wr_addr(wr_addr),
      .wr_data(ctrl.data),
      .rd_en  (map_rd_en),
      .rd_addr(ctrl.data[AW-1:0]),
      .rd_data(map_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (map_wr_en) begin
         known_ff[wr_addr] <= 1'b1;
      end
   end

   assign prev_src  = known_ff[wr_addr] ? $signed({1'b0, map_rd_data}) : PREV_UNKNOWN;
   assign changed   = !known_ff[wr_addr] || (map_rd_data != ctrl.data);
   assign dest_plus = {1'b0, ctrl.dest} + COUNT_W'(1);
   assign count_in  = (dest_plus > count_ff) ? dest_plus : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (map_wr_en) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (map_wr_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         rsp_dest_ff    <= ctrl.dest;
         rsp_src_ff     <= ctrl.data;
         rsp_prev_ff    <= prev_src;
         rsp_changed_ff <= changed;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_destination       = rsp_dest_ff;
   assign rsp_source            = rsp_src_ff;
   assign rsp_previous_source   = rsp_prev_ff;
   assign rsp_route_changed     = rsp_changed_ff;
   assign rsp_destinations_seen = rsp_count_ff;

   `CSPU_ASSERT_NEXT(a_report_loads, clock, reset, map_wr_en,
      rsp_valid_ff && (rsp_dest_ff == $past(ctrl.dest)),
      "report not loaded into output register")
   `CSPU_ASSERT_IMPLY(a_count_covers_dest, clock, reset, rsp_valid_ff,
      rsp_count_ff > COUNT_W'(rsp_dest_ff),
      "destinations_seen does not cover destination")
   `CSPU_ASSERT_IMPLY(a_unchanged_same_src, clock, reset, rsp_valid_ff && !rsp_changed_ff,
      rsp_prev_ff == $signed({1'b0, rsp_src_ff}),
      "unchanged route with differing source")

endmodule

>>> sim/crosspoint_report_checker.sv
`timescale 1ns / 1ps
// Crosspoint report checker: watches the req_, rsp_ and csr_ ports of the parser,
// keeps its own route map and parser state, and compares every report it sees.
// Depends on cspu_pkg for widths and command codes.
module crosspoint_report_checker #(
   parameter int NUM_DESTINATIONS = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [cspu_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                               req_idle_expired,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [cspu_pkg::ID_W-1:0]          rsp_destination,
   input  logic [cspu_pkg::ID_W-1:0]          rsp_source,
   input  logic signed [cspu_pkg::PREV_W-1:0] rsp_previous_source,
   input  logic                               rsp_route_changed,
   input  logic [cspu_pkg::COUNT_W-1:0]       rsp_destinations_seen,
   input  logic                               csr_wr_en,
   input  logic [cspu_pkg::LEVEL_W-1:0]       csr_wr_data,
   output int                                 fail_count,
   output int                                 pending_reports,
   output int                                 report_count,
   output int                                 changed_count
);
   import cspu_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DEST = 2'd1,
      PH_SRC  = 2'd2
   } parse_phase_type;

   typedef struct packed {
      logic [ID_W-1:0]          dest;
      logic [ID_W-1:0]          src;
      logic signed [PREV_W-1:0] prev;
      logic                     changed;
      logic [COUNT_W-1:0]       seen;
   } crosspoint_report_type;

   logic [LEVEL_W-1:0]       level_q;
   parse_phase_type          phase_q;
   logic [ID_W-1:0]          pend_dest_q;
   logic [COUNT_W-1:0]       seen_q;
   logic signed [PREV_W-1:0] route_of [NUM_DESTINATIONS];
   crosspoint_report_type    expected_reports[$];
   crosspoint_report_type    oldest;

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // advance the parser by one received byte; queue the report it completes
   task automatic take_byte(input logic [BYTE_W-1:0] rx, input logic gap_flag);
      crosspoint_report_type rpt;
      logic [ID_W-1:0]       src;
      if (gap_flag)
         phase_q = PH_IDLE;
      if (rx[CMD_BIT]) begin
         if ((rx[7:4] == CMD_AUDIO_SET || rx[7:4] == CMD_VIDEO_SET) && rx[3:0] == level_q)
            phase_q = PH_DEST;
         else
            phase_q = PH_IDLE;
      end else if (phase_q == PH_DEST) begin
         pend_dest_q = rx[ID_W-1:0];
         phase_q     = PH_SRC;
      end else if (phase_q == PH_SRC) begin
         phase_q = PH_IDLE;
         src     = rx[ID_W-1:0];
         if (int'(pend_dest_q) < NUM_DESTINATIONS) begin
            if (int'(pend_dest_q) + 1 > int'(seen_q))
               seen_q = COUNT_W'(int'(pend_dest_q) + 1);
            rpt.dest    = pend_dest_q;
            rpt.src     = src;
            rpt.prev    = route_of[pend_dest_q];
            rpt.changed = (rpt.prev != $signed({1'b0, src}));
            rpt.seen    = seen_q;
            route_of[pend_dest_q] = $signed({1'b0, src});
            expected_reports.insert(expected_reports.size(), rpt);
         end
      end else begin
         phase_q = PH_IDLE;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         level_q         = '0;
         phase_q         = PH_IDLE;
         pend_dest_q     = '0;
         seen_q          = '0;
         fail_count      = 0;
         report_count    = 0;
         changed_count   = 0;
         for (int i = 0; i < NUM_DESTINATIONS; i++)
            route_of[i] = PREV_UNKNOWN;
         expected_reports.delete();
      end else begin
         if (csr_wr_en)
            level_q = csr_wr_data;
         // reports trail their byte via the input and output registers; compare first
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected crosspoint report: destination %0d source %0d",
                      rsp_destination, rsp_source);
               fail_count++;
            end else begin
               oldest = expected_reports.pop_front();
               check_field("destination", 32'(oldest.dest), 32'(rsp_destination));
               check_field("source", 32'(oldest.src), 32'(rsp_source));
               check_field("previous_source", 32'(oldest.prev),
                           32'(rsp_previous_source));
               check_field("route_changed", 32'(oldest.changed), 32'(rsp_route_changed));
               check_field("destinations_seen", 32'(oldest.seen),
                           32'(rsp_destinations_seen));
               report_count++;
               if (oldest.changed)
                  changed_count++;
            end
         end
         if (req_valid && req_ready)
            take_byte(req_rx_byte, req_idle_expired);
      end
      pending_reports = expected_reports.size();
   end

endmodule

>>> sim/tb_crosspoint_status_parser_unit.sv
`timescale 1ns / 1ps
// Testbench top for crosspoint_status_parser_unit: clock, reset, byte stimulus,
// response back-pressure, level writes, watchdog and verdict.
// Depends on cspu_pkg, the block and crosspoint_report_checker.
module tb_crosspoint_status_parser_unit;
   import cspu_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 325;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [BYTE_W-1:0]        req_rx_byte;
   logic                     req_idle_expired;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [ID_W-1:0]          rsp_destination;
   logic [ID_W-1:0]          rsp_source;
   logic signed [PREV_W-1:0] rsp_previous_source;
   logic                     rsp_route_changed;
   logic [COUNT_W-1:0]       rsp_destinations_seen;
   logic                     csr_wr_en;
   logic [LEVEL_W-1:0]       csr_wr_data;

   int fail_count;
   int pending_reports;
   int report_count;
   int changed_count;
   int items_sent;
   int settings_used;
   int quiet_cycles;
   bit no_idle;

   crosspoint_status_parser_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_idle_expired      (req_idle_expired),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_destination       (rsp_destination),
      .rsp_source            (rsp_source),
      .rsp_previous_source   (rsp_previous_source),
      .rsp_route_changed     (rsp_route_changed),
      .rsp_destinations_seen (rsp_destinations_seen),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   crosspoint_report_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_idle_expired      (req_idle_expired),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_destination       (rsp_destination),
      .rsp_source            (rsp_source),
      .rsp_previous_source   (rsp_previous_source),
      .rsp_route_changed     (rsp_route_changed),
      .rsp_destinations_seen (rsp_destinations_seen),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .fail_count            (fail_count),
      .pending_reports       (pending_reports),
      .report_count          (report_count),
      .changed_count         (changed_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(1, 3);
      if (roll < 95)
         return $urandom_range(4, 10);
      return $urandom_range(30, 60);
   endfunction

   function automatic logic rare_flag(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // half the ids come from a narrow range so routes repeat and sources match
   function automatic logic [ID_W-1:0] pick_id(input int narrow);
      if ($urandom_range(0, 1))
         return ID_W'($urandom_range(0, narrow - 1));
      return ID_W'($urandom_range(0, 127));
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic gap_flag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_rx_byte      <= rx;
      req_idle_expired <= gap_flag;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_level(input logic [LEVEL_W-1:0] lvl);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports != 0) @(negedge clock);
      // a byte may still sit in the input register with no report due
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lvl;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // mostly well-formed set commands with random ids, some raw noise
   task automatic send_sequence(input logic [LEVEL_W-1:0] lvl);
      int               roll;
      logic [3:0]       kind;
      logic [LEVEL_W-1:0] cmd_lvl;
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
         kind    = $urandom_range(0, 1) ? CMD_AUDIO_SET : CMD_VIDEO_SET;
         cmd_lvl = ($urandom_range(0, 9) != 0) ? lvl : LEVEL_W'($urandom_range(0, 15));
         send_byte({kind, cmd_lvl}, rare_flag(4));
         if ($urandom_range(0, 19) == 0)
            send_byte({kind, cmd_lvl}, 1'b0);
         send_byte({1'b0, pick_id(8)}, rare_flag(3));
         if ($urandom_range(0, 14) != 0)
            send_byte({1'b0, pick_id(4)}, rare_flag(3));
      end else begin
         repeat ($urandom_range(1, 4))
            send_byte(BYTE_W'($urandom_range(0, 255)), rare_flag(20));
      end
   endtask

   always begin
      @(negedge clock);
      rsp_ready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(negedge clock);
      if (!no_idle && $urandom_range(0, 1)) begin
         @(negedge clock);
         rsp_ready <= 1'b0;
         repeat (pick_stall() - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [LEVEL_W-1:0] levels [5];
      int                 target;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      req_idle_expired = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      items_sent       = 0;
      settings_used    = 0;
      no_idle          = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // level 0 out of reset: data while idle, first and repeated routes
      send_byte(8'h05, 1'b0);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h90, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);   // data after a report
      send_byte(8'ha0, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h90, 1'b0);   // set command repeated
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h91, 1'b0);   // wrong level
      send_byte(8'h10, 1'b0);
      send_byte(8'hb0, 1'b0);   // other command kind
      send_byte(8'hff, 1'b0);
      send_byte(8'ha0, 1'b1);   // idle gap ahead of an arming command
      send_byte(8'h07, 1'b0);
      send_byte(8'h80, 1'b0);   // command in the source step
      send_byte(8'h90, 1'b0);
      send_byte(8'h09, 1'b0);
      send_byte(8'h0a, 1'b1);   // idle gap drops the pending destination

      write_level(4'd15);
      send_byte(8'h9f, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'haf, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);

      levels[0] = 4'd0;
      levels[1] = LEVEL_W'($urandom_range(1, 14));
      levels[2] = 4'd15;
      levels[3] = LEVEL_W'($urandom_range(0, 15));
      levels[4] = LEVEL_W'($urandom_range(0, 15));
      for (int phase = 0; phase < 5; phase++) begin
         write_level(levels[phase]);
         no_idle = (phase == 2);
         target  = items_sent + PHASE_ITEMS;
         while (items_sent < target)
            send_sequence(levels[phase]);
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports != 0) @(negedge clock);
      repeat (SETTLE_CYCLES * 2) @(negedge clock);

      $display("Run covered %0d received bytes across %0d level settings.",
               items_sent, settings_used + 1);
      $display("Checked %0d crosspoint reports, %0d of them route changes.",
               report_count, changed_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
